// ----- src/fccs_pkg.sv -----
// ----------------------------------------------------------------------------
// fccs_pkg
// Shared types and constants for the fifo code cache simulator.
// ----------------------------------------------------------------------------
package fccs_pkg;

    localparam logic [1:0] ST_HIT      = 2'd0;
    localparam logic [1:0] ST_INSERTED = 2'd1;
    localparam logic [1:0] ST_IGNORED  = 2'd2;
    localparam logic [1:0] ST_TOO_BIG  = 2'd3;

    localparam logic [15:0] CAPACITY_RESET = 16'd4096;

    // controller to datapath commands
    typedef struct packed {
        logic start;      // latch input word, reset search
        logic rd_search;  // issue memory read at search pointer
        logic step_search;
        logic rd_head;    // issue memory read at head
        logic evict;      // pop oldest entry using read data
        logic insert;     // append block
        logic out_load;   // load result register
        logic flush;
    } fccs_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic size_zero;
        logic search_done;
        logic id_match;
        logic too_big;
        logic need_evict;
    } fccs_sts_t;

endpackage

// ----- src/fccs_if.sv -----
// ----------------------------------------------------------------------------
// fccs channel interfaces
// Valid/ready channels for block words, result words and config writes.
// ----------------------------------------------------------------------------
interface fccs_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] block_id;
    logic [15:0] block_size;
    modport source (output valid, block_id, block_size, input ready);
    modport sink   (input valid, block_id, block_size, output ready);
endinterface

interface fccs_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [12:0] evicted_count;
    logic [31:0] instr_total;
    modport source (output valid, status, evicted_count, instr_total, input ready);
    modport sink   (input valid, status, evicted_count, instr_total, output ready);
endinterface

interface fccs_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ----- src/fccs_datapath.sv -----
// ----------------------------------------------------------------------------
// fccs_datapath
// Ring memories, pointers, byte budget, counters and result register.
// ----------------------------------------------------------------------------
module fccs_datapath
    import fccs_pkg::*;
#(
    parameter int RING_DEPTH = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  fccs_cmd_t   cmd,
    output fccs_sts_t   sts,
    input  logic [15:0] in_id,
    input  logic [15:0] in_size,
    input  logic [15:0] cfg_data,
    output logic [1:0]  res_status,
    output logic [12:0] res_evicted,
    output logic [31:0] res_total,
    input  logic [1:0]  status_code
);

    localparam int PW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(RING_DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(RING_DEPTH);

    logic [15:0] ids_mem   [RING_DEPTH];
    logic [15:0] sizes_mem [RING_DEPTH];

    logic [PW-1:0] head_reg, tail_reg, srch_reg;
    logic [CW-1:0] count_reg, scnt_reg;
    logic [15:0]   free_reg, cap_reg;
    logic [31:0]   instr_reg;
    logic [12:0]   evc_reg;
    logic [15:0]   id_reg, size_reg;
    logic [15:0]   rd_id_reg, rd_size_reg;

    function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
        return (p == LAST) ? '0 : p + 1'b1;
    endfunction

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.insert)
        begin
            ids_mem[tail_reg]   <= id_reg;
            sizes_mem[tail_reg] <= size_reg;
        end
        if (cmd.rd_search)
            rd_id_reg <= ids_mem[srch_reg];
        if (cmd.rd_head)
            rd_size_reg <= sizes_mem[head_reg];
    end

    // input word latch
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            id_reg   <= in_id;
            size_reg <= in_size;
        end
    end

    // ring state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            srch_reg  <= '0;
            count_reg <= '0;
            scnt_reg  <= '0;
            free_reg  <= CAPACITY_RESET;
            cap_reg   <= CAPACITY_RESET;
            instr_reg <= '0;
            evc_reg   <= '0;
        end
        else if (cmd.flush)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            cap_reg   <= cfg_data;
            free_reg  <= cfg_data;
        end
        else
        begin
            if (cmd.start)
            begin
                srch_reg <= head_reg;
                scnt_reg <= '0;
                evc_reg  <= '0;
            end
            if (cmd.step_search)
            begin
                srch_reg <= nxt(srch_reg);
                scnt_reg <= scnt_reg + 1'b1;
            end
            if (cmd.evict)
            begin
                free_reg  <= free_reg + rd_size_reg;
                head_reg  <= nxt(head_reg);
                count_reg <= count_reg - 1'b1;
                evc_reg   <= evc_reg + 1'b1;
            end
            if (cmd.insert)
            begin
                free_reg  <= free_reg - size_reg;
                tail_reg  <= nxt(tail_reg);
                count_reg <= count_reg + 1'b1;
                instr_reg <= instr_reg + 32'(size_reg[15:2]);
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            res_status  <= status_code;
            res_evicted <= (status_code == ST_INSERTED) ? evc_reg : '0;
            res_total   <= cmd.insert ? instr_reg + 32'(size_reg[15:2]) : instr_reg;
        end
    end

    // status toward the controller
    always_comb
    begin
        sts.size_zero   = (size_reg == '0);
        sts.search_done = (scnt_reg == count_reg);
        sts.id_match    = (rd_id_reg == id_reg);
        sts.too_big     = (size_reg > cap_reg);
        sts.need_evict  = (count_reg != '0) &&
                          ((free_reg < size_reg) || (count_reg == FULL));
    end

endmodule

// ----- src/fccs_ctrl.sv -----
// ----------------------------------------------------------------------------
// fccs_ctrl
// Sequencer for search, eviction walk, insert and result handoff.
// ----------------------------------------------------------------------------
module fccs_ctrl
    import fccs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       out_ready,
    output logic       out_valid,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  fccs_sts_t  sts,
    output fccs_cmd_t  cmd,
    output logic [1:0] status_code
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_CMP    = 3'd2;
    localparam logic [2:0] S_EVCHK  = 3'd3;
    localparam logic [2:0] S_EVRD   = 3'd4;
    localparam logic [2:0] S_EVAPP  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       ov_reg, ov_next;

    // output word is held until taken; a new word may load only when free
    logic out_free;
    assign out_free  = !ov_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE) && !ov_reg;
    assign out_valid = ov_reg;

    always_comb
    begin
        cmd         = '0;
        state_next  = state_reg;
        ov_next     = ov_reg && !out_ready;
        status_code = ST_HIT;
        case (state_reg)
            S_IDLE:
            begin
                if (cfg_valid && cfg_ready)
                    cmd.flush = 1'b1;
                else if (in_valid && in_ready)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.size_zero)
                begin
                    status_code = ST_IGNORED;
                    if (out_free)
                    begin
                        cmd.out_load = 1'b1;
                        ov_next      = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
                else if (sts.search_done)
                begin
                    if (sts.too_big)
                    begin
                        status_code = ST_TOO_BIG;
                        if (out_free)
                        begin
                            cmd.out_load = 1'b1;
                            ov_next      = 1'b1;
                            state_next   = S_IDLE;
                        end
                    end
                    else
                        state_next = S_EVCHK;
                end
                else
                begin
                    cmd.rd_search = 1'b1;
                    state_next    = S_CMP;
                end
            end
            S_CMP:
            begin
                if (sts.id_match)
                begin
                    status_code = ST_HIT;
                    if (out_free)
                    begin
                        cmd.out_load = 1'b1;
                        ov_next      = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
                else
                begin
                    cmd.step_search = 1'b1;
                    state_next      = S_CHECK;
                end
            end
            S_EVCHK:
            begin
                status_code = ST_INSERTED;
                if (sts.need_evict)
                begin
                    cmd.rd_head = 1'b1;
                    state_next  = S_EVRD;
                end
                else
                    state_next = S_EVAPP;
            end
            S_EVRD:
            begin
                cmd.evict  = 1'b1;
                state_next = S_EVCHK;
            end
            S_EVAPP:
            begin
                status_code = ST_INSERTED;
                if (out_free)
                begin
                    cmd.insert   = 1'b1;
                    cmd.out_load = 1'b1;
                    ov_next      = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

endmodule

// ----- src/fifo_code_cache_simulator_unit.sv -----
// ----------------------------------------------------------------------------
// fifo_code_cache_simulator_unit
// Byte-budgeted code cache with fifo eviction, one result word per block word.
// ----------------------------------------------------------------------------
// Each block word of nonzero size is checked for presence by a search over the
// N resident entries (one ring memory read and compare per entry); then, if it
// is absent and not too big, the oldest entries are evicted as needed and it is
// inserted. The worst case is set by the sequential walk of the single-port ring memory.
// A result word is held in an output register until taken. Writing the
// capacity register flushes the ring; no clearing pass is needed.
module fifo_code_cache_simulator_unit
    import fccs_pkg::*;
#(
    parameter int RING_DEPTH = 4096
)
(
    input logic clk,
    input logic rst_n,
    fccs_in_if.sink    in_ch,
    fccs_out_if.source out_ch,
    fccs_cfg_if.sink   cfg
);

    fccs_cmd_t  cmd;
    fccs_sts_t  sts;
    logic [1:0] status_code;

    fccs_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_ch.valid),
        .in_ready    (in_ch.ready),
        .out_ready   (out_ch.ready),
        .out_valid   (out_ch.valid),
        .cfg_valid   (cfg.valid),
        .cfg_ready   (cfg.ready),
        .sts         (sts),
        .cmd         (cmd),
        .status_code (status_code)
    );

    fccs_datapath #(.RING_DEPTH(RING_DEPTH)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .in_id       (in_ch.block_id),
        .in_size     (in_ch.block_size),
        .cfg_data    (cfg.data),
        .res_status  (out_ch.status),
        .res_evicted (out_ch.evicted_count),
        .res_total   (out_ch.instr_total),
        .status_code (status_code)
    );

endmodule
